// ----- hdl/run_queue_priority_dispatch_assert.svh -----
// -----------------------------------------------------------------------------
// Run queue dispatch assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// -----------------------------------------------------------------------------
`ifndef RUN_QUEUE_PRIORITY_DISPATCH_ASSERT_SVH
`define RUN_QUEUE_PRIORITY_DISPATCH_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define RQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RQ_ASSERT_NOW(lbl, ante, cons, msg)
`define RQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/rqpd_pkg.sv -----
// -----------------------------------------------------------------------------
// Run queue dispatch package
// Sizes, slot layout and command/status/state codes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rqpd_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int IDX_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int PRIORITY_BITS = 16;
  localparam int ID_W          = 8;
  localparam int PRIO_IO_W     = 16;
  localparam int CPU_W         = 3;
  localparam int QCNT_W        = 7;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic [PRIORITY_BITS-1:0] prio;
    logic                     wired;
    logic [CPU_W-1:0]         wcpu;
    logic                     yld;
    logic                     hld;
  } slot_t;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_REL = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_FULL      = 2'd1,
    STS_NONE      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIX,
    S_SHIFT,
    S_RESP
  } state_t;

endpackage

// ----- hdl/run_queue_priority_dispatch.sv -----
// -----------------------------------------------------------------------------
// Run queue priority dispatch
// FIFO run queue with a sequential lowest-priority pick for a task scheduler.
// -----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_* and pulse start while busy is low; the
//   command transfers at that edge and busy stays high until the result.
//   Result channel: out_valid is high for exactly one cycle with out_status,
//   out_chosen_id, out_chosen_priority and out_queue_count. The receiver
//   cannot stall it; busy drops the cycle after the strobe, so a new command
//   may be issued as soon as busy is low.
//   An enqueue or unused command goes straight to its result. A release or
//   dequeue first scans every slot; a dequeue that finds a task then shifts
//   the slots above the taken one down by one before the result.
//   One memory with a single read and a single write port carries the slots.
//   The scan reads one slot a cycle; the removal shift moves one slot a cycle.
//   Reset: queue empties, sequencer idles; slot contents are left as is.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "run_queue_priority_dispatch_assert.svh"

module run_queue_priority_dispatch
  import rqpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic [ID_W-1:0]      in_task_id,
  input  logic [PRIO_IO_W-1:0] in_priority_req,
  input  logic                 in_is_wired,
  input  logic [CPU_W-1:0]     in_wired_cpu,
  input  logic                 in_yield_flag,
  input  logic                 in_held,
  input  logic [CPU_W-1:0]     in_cpu,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [ID_W-1:0]      out_chosen_id,
  output logic [PRIO_IO_W-1:0] out_chosen_priority,
  output logic [QCNT_W-1:0]    out_queue_count
);

  // Slot memory: one write port, one registered read port.
  slot_t mem [QUEUE_DEPTH];

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]         occ_r, occ_nxt;         // occupancy
  logic [CNT_W-1:0]         issue_r, issue_nxt;     // next slot to read
  logic                     rd_vld_r, rd_vld_nxt;   // rd_data_r holds a slot
  logic [IDX_W-1:0]         rd_idx_r;               // which slot it is
  slot_t                    rd_data_r;

  cmd_t                     cmd_r, cmd_nxt;
  logic [ID_W-1:0]          tid_r, tid_nxt;
  logic [CPU_W-1:0]         cpu_r, cpu_nxt;
  status_t                  sts_r, sts_nxt;

  // Scan results. For a release, "first" is the matching slot.
  logic                     have_r, have_nxt;
  logic [IDX_W-1:0]         first_idx_r, first_idx_nxt;
  slot_t                    first_word_r, first_word_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [PRIORITY_BITS-1:0] best_prio_r, best_prio_nxt;
  logic [ID_W-1:0]          best_id_r, best_id_nxt;

  logic                     accept;
  logic                     full;
  logic                     issuing;
  logic                     pipe_empty;
  logic                     scan_phase;
  logic                     eligible;
  logic                     we;
  logic [IDX_W-1:0]         wa;
  slot_t                    wd;

  assign accept     = start && (state_r == S_IDLE);
  assign full       = (occ_r == CNT_W'(QUEUE_DEPTH));
  assign issuing    = ((state_r == S_SCAN) || (state_r == S_SHIFT)) && (issue_r < occ_r);
  assign pipe_empty = !issuing && !rd_vld_r;
  assign scan_phase = (state_r == S_SCAN) || (state_r == S_FIX);

  // Not held, and either unwired or wired to the requesting cpu.
  assign eligible = !rd_data_r.hld && !(rd_data_r.wired && (rd_data_r.wcpu != cpu_r));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (cmd_t'(in_cmd) == CMD_DEQ || cmd_t'(in_cmd) == CMD_REL) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (pipe_empty) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (cmd_r == CMD_DEQ && have_r) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        if (pipe_empty) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Port outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    busy                = (state_r != S_IDLE);
    out_valid           = (state_r == S_RESP);
    out_status          = sts_r;
    out_queue_count     = QCNT_W'(occ_r);
    out_chosen_id       = '0;
    out_chosen_priority = '0;
    if (cmd_r == CMD_DEQ && have_r && sts_r == STS_DONE) begin
      out_chosen_id       = best_id_r;
      out_chosen_priority = PRIO_IO_W'(best_prio_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath next values and memory write port
  // ---------------------------------------------------------------------------
  always_comb begin
    occ_nxt        = occ_r;
    issue_nxt      = issue_r;
    cmd_nxt        = cmd_r;
    tid_nxt        = tid_r;
    cpu_nxt        = cpu_r;
    sts_nxt        = sts_r;
    have_nxt       = have_r;
    first_idx_nxt  = first_idx_r;
    first_word_nxt = first_word_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    best_id_nxt    = best_id_r;
    rd_vld_nxt     = issuing;
    we             = 1'b0;
    wa             = occ_r[IDX_W-1:0];
    wd.id          = in_task_id;
    wd.prio        = in_priority_req[PRIORITY_BITS-1:0];
    wd.wired       = in_is_wired;
    wd.wcpu        = in_wired_cpu;
    wd.yld         = in_yield_flag;
    wd.hld         = in_held;

    if (issuing) begin
      issue_nxt = issue_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = cmd_t'(in_cmd);
          tid_nxt   = in_task_id;
          cpu_nxt   = in_cpu;
          have_nxt  = 1'b0;
          issue_nxt = '0;
          sts_nxt   = STS_DONE;
          if (cmd_t'(in_cmd) == CMD_ENQ) begin
            if (full) begin
              sts_nxt = STS_FULL;
            end else begin
              we      = 1'b1;
              occ_nxt = occ_r + 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_r) begin
          if (cmd_r == CMD_DEQ) begin
            priority if (eligible && !have_r) begin
              have_nxt       = 1'b1;
              first_idx_nxt  = rd_idx_r;
              first_word_nxt = rd_data_r;
              best_idx_nxt   = rd_idx_r;
              best_prio_nxt  = rd_data_r.prio;
              best_id_nxt    = rd_data_r.id;
            end else if (eligible && !rd_data_r.yld && (rd_data_r.prio < best_prio_r)) begin
              best_idx_nxt  = rd_idx_r;
              best_prio_nxt = rd_data_r.prio;
              best_id_nxt   = rd_data_r.id;
            end
          end else if (!have_r && rd_data_r.id == tid_r) begin
            have_nxt       = 1'b1;
            first_idx_nxt  = rd_idx_r;
            first_word_nxt = rd_data_r;
          end
        end
      end
      S_FIX: begin
        // Write back the first eligible slot with yield cleared, or the
        // released slot with held cleared.
        wa = first_idx_r;
        wd = first_word_r;
        if (cmd_r == CMD_DEQ) begin
          wd.yld    = 1'b0;
          issue_nxt = {1'b0, best_idx_r} + 1'b1;
          sts_nxt   = have_r ? STS_DONE : STS_NONE;
        end else begin
          wd.hld  = 1'b0;
          sts_nxt = have_r ? STS_DONE : STS_NOT_FOUND;
        end
        we = have_r;
      end
      S_SHIFT: begin
        // Slot i+1 moves down to slot i.
        wa = rd_idx_r - 1'b1;
        wd = rd_data_r;
        we = rd_vld_r;
        if (pipe_empty) begin
          occ_nxt = occ_r - 1'b1;
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      rd_vld_r <= 1'b0;
      have_r   <= 1'b0;
      cmd_r    <= CMD_ENQ;
      sts_r    <= STS_DONE;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      rd_vld_r <= rd_vld_nxt;
      have_r   <= have_nxt;
      cmd_r    <= cmd_nxt;
      sts_r    <= sts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_r      <= issue_nxt;
    rd_idx_r     <= issue_r[IDX_W-1:0];
    tid_r        <= tid_nxt;
    cpu_r        <= cpu_nxt;
    first_idx_r  <= first_idx_nxt;
    first_word_r <= first_word_nxt;
    best_idx_r   <= best_idx_nxt;
    best_prio_r  <= best_prio_nxt;
    best_id_r    <= best_id_nxt;
  end

  // Slot memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[issue_r[IDX_W-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
  `RQ_ASSERT_NOW(a_full_status, out_valid && sts_r == STS_FULL, full, "full reported with room")
  `RQ_ASSERT_NEXT(a_scan_occ, scan_phase, $stable(occ_r), "occupancy moved during scan")
  `RQ_ASSERT_NEXT(a_resp_idle, out_valid, !busy && !out_valid, "result strobe over one cycle")

endmodule

// ----- verif/tb.sv -----
// -----------------------------------------------------------------------------
// Run queue dispatch testbench
// Drives enqueue, dequeue and release commands into the run queue and checks
// every result strobe against a cycle-free shadow of the queue kept here.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rqpd_pkg::*;

  // cmd_t covers only the three real commands; the fourth encoding is a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Longest quiet stretch: a dequeue on a full queue scans 64 slots and
  // shifts up to 63 more, plus the longest sender gap.
  localparam int STALL_LIMIT   = 1000;
  localparam int CHUNK_ITEMS   = 50;
  localparam int RANDOM_CHUNKS = 18;

  typedef struct packed {
    status_t                status;
    logic [ID_W-1:0]        chosen_id;
    logic [PRIO_IO_W-1:0]   chosen_prio;
    logic [QCNT_W-1:0]      queue_count;
  } dispatch_resp_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_cmd;
  logic [ID_W-1:0]      in_task_id;
  logic [PRIO_IO_W-1:0] in_priority_req;
  logic                 in_is_wired;
  logic [CPU_W-1:0]     in_wired_cpu;
  logic                 in_yield_flag;
  logic                 in_held;
  logic [CPU_W-1:0]     in_cpu;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [ID_W-1:0]      out_chosen_id;
  logic [PRIO_IO_W-1:0] out_chosen_priority;
  logic [QCNT_W-1:0]    out_queue_count;

  // Shadow of the run queue: slot 0 is the head, shadow_count the occupancy.
  slot_t          shadow_slot [QUEUE_DEPTH];
  int             shadow_count;
  // Results owed by the block, oldest first.
  dispatch_resp_t resp_due_q [$];
  int             err_cnt;
  int             idle_cycles;
  bit             gaps_on;

  run_queue_priority_dispatch uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_task_id          (in_task_id),
    .in_priority_req     (in_priority_req),
    .in_is_wired         (in_is_wired),
    .in_wired_cpu        (in_wired_cpu),
    .in_yield_flag       (in_yield_flag),
    .in_held             (in_held),
    .in_cpu              (in_cpu),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_chosen_id       (out_chosen_id),
    .out_chosen_priority (out_chosen_priority),
    .out_queue_count     (out_queue_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow queue update for one accepted command; returns the result it owes.
  // ---------------------------------------------------------------------------
  function automatic dispatch_resp_t predict_dispatch(
    input logic [1:0]           cmd,
    input logic [ID_W-1:0]      id,
    input logic [PRIO_IO_W-1:0] prio,
    input logic                 wired,
    input logic [CPU_W-1:0]     wcpu,
    input logic                 yld,
    input logic                 hld,
    input logic [CPU_W-1:0]     cpu
  );
    dispatch_resp_t r;
    bit             have;
    int             best;
    r      = '0;
    r.status = STS_DONE;
    have   = 1'b0;
    best   = 0;
    case (cmd)
      CMD_ENQ: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          // truncation to PRIORITY_BITS is the priority mask
          shadow_slot[shadow_count].id    = id;
          shadow_slot[shadow_count].prio  = prio[PRIORITY_BITS-1:0];
          shadow_slot[shadow_count].wired = wired;
          shadow_slot[shadow_count].wcpu  = wcpu;
          shadow_slot[shadow_count].yld   = yld;
          shadow_slot[shadow_count].hld   = hld;
          shadow_count++;
        end
      end
      CMD_DEQ: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_slot[i].hld) continue;
          if (shadow_slot[i].wired && shadow_slot[i].wcpu != cpu) continue;
          if (!have) begin
            // first eligible task: initial pick, loses its yield mark
            shadow_slot[i].yld = 1'b0;
            best = i;
            have = 1'b1;
          end else if (!shadow_slot[i].yld &&
                       shadow_slot[i].prio < shadow_slot[best].prio) begin
            best = i;
          end
        end
        if (!have) begin
          r.status = STS_NONE;
        end else begin
          r.chosen_id   = shadow_slot[best].id;
          r.chosen_prio = PRIO_IO_W'(shadow_slot[best].prio);
          for (int i = best; i + 1 < shadow_count; i++)
            shadow_slot[i] = shadow_slot[i + 1];
          shadow_count--;
        end
      end
      CMD_REL: begin
        r.status = STS_NOT_FOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_slot[i].id == id) begin
            shadow_slot[i].hld = 1'b0;
            r.status = STS_DONE;
            break;
          end
        end
      end
      default: begin
        // unused command: no state change, plain done
      end
    endcase
    r.queue_count = QCNT_W'(shadow_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Mostly back-to-back or short gaps, now and then a long one.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(99);
    if (!gaps_on || r < 55) n = 0;
    else if (r < 90)        n = $urandom_range(3, 1);
    else                    n = $urandom_range(40, 5);
    repeat (n) @(negedge clk);
  endtask

  // One command transfer: raise start at a falling edge, hold until an edge
  // sees busy low, then log the owed result and drop start.
  task automatic send_cmd(
    input logic [1:0]           cmd,
    input logic [ID_W-1:0]      id,
    input logic [PRIO_IO_W-1:0] prio,
    input logic                 wired,
    input logic [CPU_W-1:0]     wcpu,
    input logic                 yld,
    input logic                 hld,
    input logic [CPU_W-1:0]     cpu
  );
    @(negedge clk);
    in_cmd          = cmd;
    in_task_id      = id;
    in_priority_req = prio;
    in_is_wired     = wired;
    in_wired_cpu    = wcpu;
    in_yield_flag   = yld;
    in_held         = hld;
    in_cpu          = cpu;
    start           = 1'b1;
    do @(posedge clk); while (busy);
    resp_due_q.push_back(predict_dispatch(cmd, id, prio, wired, wcpu, yld, hld, cpu));
    @(negedge clk);
    start = 1'b0;
    idle_gap();
  endtask

  // Unused fields of each command carry random noise.
  task automatic enq(input logic [ID_W-1:0] id, input logic [PRIO_IO_W-1:0] prio,
                     input logic wired, input logic [CPU_W-1:0] wcpu,
                     input logic yld, input logic hld);
    send_cmd(CMD_ENQ, id, prio, wired, wcpu, yld, hld, CPU_W'($urandom));
  endtask

  task automatic deq(input logic [CPU_W-1:0] cpu);
    send_cmd(CMD_DEQ, ID_W'($urandom), PRIO_IO_W'($urandom), 1'($urandom),
             CPU_W'($urandom), 1'($urandom), 1'($urandom), cpu);
  endtask

  task automatic rel(input logic [ID_W-1:0] id);
    send_cmd(CMD_REL, id, PRIO_IO_W'($urandom), 1'($urandom),
             CPU_W'($urandom), 1'($urandom), 1'($urandom), CPU_W'($urandom));
  endtask

  // Sender holds off until the block owes nothing.
  task automatic wait_drained();
    while (resp_due_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes, every command and each corner of the pick rule.
  task automatic test_directed();
    deq(3'd3);                                   // empty queue: nothing eligible
    rel(8'h42);                                  // release on empty: not found
    send_cmd(CMD_UNUSED, '1, '1, 1'b1, '1, 1'b1, 1'b1, '1);
    enq(8'hFF, 16'hFFFF, 1'b0, 3'd0, 1'b0, 1'b0);
    enq(8'h00, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0);
    deq(3'd0);                                   // lower number wins: id 0
    deq(3'd0);                                   // then id 255, priority max
    enq(8'h01, 16'd10, 1'b1, 3'd7, 1'b0, 1'b0);  // wired to cpu 7
    deq(3'd0);                                   // wired elsewhere: none
    deq(3'd7);
    enq(8'h02, 16'd4, 1'b0, 3'd0, 1'b0, 1'b1);   // held
    enq(8'h03, 16'd9, 1'b0, 3'd0, 1'b0, 1'b0);
    deq(3'd5);                                   // held skipped: id 3
    deq(3'd5);                                   // only held left: none
    rel(8'h02);
    deq(3'd5);                                   // released one now runs
    // yield chain: D(5,y) E(3,y) F(5) G(2) -> picks G, D, E, F
    enq(8'h04, 16'd5, 1'b0, 3'd0, 1'b1, 1'b0);
    enq(8'h05, 16'd3, 1'b0, 3'd0, 1'b1, 1'b0);
    enq(8'h06, 16'd5, 1'b0, 3'd0, 1'b0, 1'b0);
    enq(8'h07, 16'd2, 1'b0, 3'd0, 1'b0, 1'b0);
    repeat (4) deq(3'd2);
  endtask

  // Fill to capacity, overflow once, then drain with one dequeue past empty.
  task automatic test_queue_full();
    int i;
    i = 0;
    while (shadow_count < QUEUE_DEPTH) begin
      enq(ID_W'(i), PRIO_IO_W'($urandom_range(31)), 1'b0, CPU_W'($urandom),
          1'($urandom_range(3) == 0), 1'b0);
      i++;
    end
    enq(8'hA5, 16'h1234, 1'b1, 3'd4, 1'b1, 1'b1); // full: nothing stored
    repeat (QUEUE_DEPTH + 1) deq(CPU_W'($urandom));
  endtask

  // One well-formed random command; enq_pct steers the occupancy drift.
  task automatic random_cmd(input int enq_pct);
    int               r;
    logic [ID_W-1:0]  id;
    logic [PRIO_IO_W-1:0] prio;
    r = $urandom_range(99);
    if (r < 3) begin
      send_cmd(CMD_UNUSED, ID_W'($urandom), PRIO_IO_W'($urandom), 1'($urandom),
               CPU_W'($urandom), 1'($urandom), 1'($urandom), CPU_W'($urandom));
    end else if (r < 3 + enq_pct) begin
      // small id pool now and then, so releases hit duplicates
      id   = ($urandom_range(99) < 30) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
      // small priorities give ties and near-ties
      prio = ($urandom_range(99) < 60) ? PRIO_IO_W'($urandom_range(15))
                                       : PRIO_IO_W'($urandom);
      enq(id, prio, 1'($urandom_range(99) < 30), CPU_W'($urandom),
          1'($urandom_range(99) < 30), 1'($urandom_range(99) < 15));
    end else if (r < 15 + enq_pct) begin
      if (shadow_count > 0 && $urandom_range(3) != 0)
        id = shadow_slot[$urandom_range(shadow_count - 1)].id;
      else
        id = ID_W'($urandom);
      rel(id);
    end else begin
      deq(CPU_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int enq_pct;
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      case ($urandom_range(2))
        0:       enq_pct = 25;
        1:       enq_pct = 42;
        default: enq_pct = 58;
      endcase
      gaps_on = ($urandom_range(3) != 0);
      repeat (CHUNK_ITEMS) random_cmd(enq_pct);
      if (c % 4 == 3) wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result check: every strobe is matched against the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dispatch_resp_t want;
    if (rst_n && out_valid) begin
      if (resp_due_q.size() == 0) begin
        $error("result strobe with no command outstanding");
        err_cnt++;
      end else begin
        want = resp_due_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          err_cnt++;
        end
        if (out_chosen_id !== want.chosen_id) begin
          $error("chosen_id: expected %0d, actual %0d", want.chosen_id, out_chosen_id);
          err_cnt++;
        end
        if (out_chosen_priority !== want.chosen_prio) begin
          $error("chosen_priority: expected %0d, actual %0d",
                 want.chosen_prio, out_chosen_priority);
          err_cnt++;
        end
        if (out_queue_count !== want.queue_count) begin
          $error("queue_count: expected %0d, actual %0d",
                 want.queue_count, out_queue_count);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: quiet cycles are those with neither a command nor a result transfer.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_cmd          = CMD_ENQ;
    in_task_id      = '0;
    in_priority_req = '0;
    in_is_wired     = 1'b0;
    in_wired_cpu    = '0;
    in_yield_flag   = 1'b0;
    in_held         = 1'b0;
    in_cpu          = '0;
    err_cnt         = 0;
    idle_cycles     = 0;
    shadow_count    = 0;
    gaps_on         = 1'b1;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_queue_full();
    test_random_traffic();

    // let the last results land, then a dequeue's worth of quiet for strays
    while (resp_due_q.size() != 0) @(posedge clk);
    repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);
    if (err_cnt == 0 && resp_due_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
